// ===== rtl/positional_list_engine_core_macros.svh =====
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define PLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ple_pkg.sv =====
package ple_pkg;

  // Field widths fixed by the command and result formats
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 7;
  localparam int ELEM_W  = 32;
  localparam int STAT_W  = 2;
  localparam int INDEX_W = 6;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_POS   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_END   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REM_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REM_POS   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_REM_END   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_DUMP      = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] element;
  } ple_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ELEM_W-1:0]  item_value;
    logic [INDEX_W-1:0] item_index;
    logic               last;
  } ple_res_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_DUMP
  } ple_op_t;

  // Decoded command handed from the decoder to the sequencer
  typedef struct packed {
    logic [STAT_W-1:0] status;
    ple_op_t           op;
    logic [POS_W-1:0]  pos;
  } ple_dec_t;

endpackage

// ===== rtl/positional_list_engine_core.sv =====
// Ordered list of 32-bit handles held in one single-port-write RAM.
// Request channel (cmd_valid/cmd_stall/cmd) carries func, position, element;
// a request is taken when cmd_valid is high and cmd_stall is low. The block
// works on one request at a time and raises cmd_stall until it is done.
// Result channel (res_valid/res_stall/res) carries status, item_value,
// item_index and last; a result stays in its output register while
// res_stall is high, and the next request may start meanwhile.
// Steps from the accepting edge until res_valid rises, with count entries
// and target position p:
//   rejected request or unused code: straight to the result register
//   insert at p: move entries p..count-1 up one slot (none if p equals
//     count), then write the element at p
//   remove at p: read entry p as the result, move entries above it down
//   dump: one entry per cycle while the receiver does not stall.
// Each move is one registered read and one write through the RAM, addressed
// by a single increment/decrement pointer unit; receiver stalls hold the
// result in its register.
// Reset empties the list (count to zero) and drops any pending result; the
// RAM contents are not cleared, as entries are only read after a write.
module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  ple_cmd_t cmd,
  output logic     res_valid,
  input  logic     res_stall,
  output ple_res_t res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_RESP,
    S_DUMP
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [AW-1:0]      rd_ptr;
  logic [AW-1:0]      prev_ptr;
  logic [AW-1:0]      end_ptr;
  logic [AW-1:0]      wa;
  logic [AW-1:0]      put_pos;
  logic               dir_dec;
  logic               pend;
  logic               first;
  logic               issue_first;
  logic               is_insert;
  logic [ELEM_W-1:0]  elem;
  logic [STAT_W-1:0]  res_status;
  logic [ELEM_W-1:0]  res_value;

  ple_dec_t           dec;
  logic [AW-1:0]      ptr_step;
  logic               out_free;
  logic               res_load;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ELEM_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ELEM_W-1:0]  ram_rdata;

  ple_decode #(.CAPACITY(CAPACITY)) u_dec (
    .cmd   (cmd),
    .count (POS_W'(count)),
    .dec   (dec)
  );

  ple_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;
  assign res_load  = out_free && (state == S_RESP || state == S_DUMP);

  // Shared pointer unit: one step up or down the list
  assign ptr_step = rd_ptr + (dir_dec ? {AW{1'b1}} : AW'(1));

  // Drive RAM addresses and data for the current step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wa;
    ram_wdata = ram_rdata;
    ram_raddr = rd_ptr;
    unique case (state)
      S_IDLE: ram_raddr = '0;
      S_SHIFT, S_DRAIN: ram_we = pend && !first;
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = put_pos;
        ram_wdata = elem;
      end
      S_DUMP: begin
        if (out_free && (rd_ptr != end_ptr)) begin
          ram_raddr = ptr_step;
        end
      end
      default: ;
    endcase
  end

  // Sequencer, list count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      // Hold a stalled result, load a new one once the register frees up
      res_valid <= res_load || (res_valid && res_stall);
      // Capture the removed entry when its read returns
      if ((state == S_SHIFT || state == S_DRAIN) && pend && first) begin
        res_value <= ram_rdata;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res_status  <= dec.status;
            res_value   <= '0;
            pend        <= 1'b0;
            first       <= 1'b0;
            issue_first <= 1'b0;
            unique case (dec.op)
              OP_NONE: state <= S_RESP;
              OP_INSERT: begin
                put_pos   <= dec.pos[AW-1:0];
                elem      <= cmd.element;
                is_insert <= 1'b1;
                dir_dec   <= 1'b1;
                rd_ptr    <= AW'(count - 1'b1);
                prev_ptr  <= AW'(count);
                end_ptr   <= dec.pos[AW-1:0];
                state     <= (dec.pos == POS_W'(count)) ? S_PUT : S_SHIFT;
              end
              OP_REMOVE: begin
                is_insert   <= 1'b0;
                dir_dec     <= 1'b0;
                issue_first <= 1'b1;
                rd_ptr      <= dec.pos[AW-1:0];
                prev_ptr    <= dec.pos[AW-1:0];
                end_ptr     <= AW'(count - 1'b1);
                state       <= S_SHIFT;
              end
              OP_DUMP: begin
                dir_dec <= 1'b0;
                rd_ptr  <= '0;
                end_ptr <= AW'(count - 1'b1);
                state   <= S_DUMP;
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_SHIFT: begin
          // Issue one read; its data lands one address over next cycle
          pend        <= 1'b1;
          first       <= issue_first;
          issue_first <= 1'b0;
          wa          <= prev_ptr;
          prev_ptr    <= rd_ptr;
          if (rd_ptr == end_ptr) begin
            state <= S_DRAIN;
          end else begin
            rd_ptr <= ptr_step;
          end
        end
        S_DRAIN: begin
          pend  <= 1'b0;
          first <= 1'b0;
          if (is_insert) begin
            state <= S_PUT;
          end else begin
            count <= count - 1'b1;
            state <= S_RESP;
          end
        end
        S_PUT: begin
          count <= count + 1'b1;
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            res.status     <= res_status;
            res.item_value <= res_value;
            res.item_index <= '0;
            res.last       <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_DUMP: begin
          // Hand out one entry per cycle while the receiver takes them
          if (out_free) begin
            res.status     <= ST_OK;
            res.item_value <= ram_rdata;
            res.item_index <= INDEX_W'(rd_ptr);
            res.last       <= (rd_ptr == end_ptr);
            if (rd_ptr == end_ptr) begin
              state <= S_IDLE;
            end else begin
              rd_ptr <= ptr_step;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ple_ram.sv =====
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ple_decode.sv =====
module ple_decode
  import ple_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  ple_cmd_t         cmd,
  input  logic [POS_W-1:0] count,
  output ple_dec_t         dec
);

  logic [POS_W-1:0] pos;
  logic             is_ins;
  logic             is_rem;

  // Pick the target position for each function code
  always_comb begin
    pos    = '0;
    is_ins = 1'b0;
    is_rem = 1'b0;
    dec    = '{status: ST_OK, op: OP_NONE, pos: '0};
    unique case (cmd.func)
      FN_INS_FRONT: begin is_ins = 1'b1; pos = '0;           end
      FN_INS_POS:   begin is_ins = 1'b1; pos = cmd.position; end
      FN_INS_END:   begin is_ins = 1'b1; pos = count;        end
      FN_REM_FRONT: begin is_rem = 1'b1; pos = '0;           end
      FN_REM_POS:   begin is_rem = 1'b1; pos = cmd.position; end
      FN_REM_END:   begin is_rem = 1'b1; pos = count - 1'b1; end
      FN_DUMP: begin
        if (count == '0) begin
          dec.status = ST_EMPTY;
        end else begin
          dec.op = OP_DUMP;
        end
      end
      default: ;
    endcase

    // Fullness and emptiness take precedence over the range check
    if (is_ins) begin
      if (count >= POS_W'(CAPACITY)) begin
        dec.status = ST_FULL;
      end else if (pos > count) begin
        dec.status = ST_RANGE;
      end else begin
        dec.op  = OP_INSERT;
        dec.pos = pos;
      end
    end
    if (is_rem) begin
      if (count == '0) begin
        dec.status = ST_EMPTY;
      end else if (pos >= count) begin
        dec.status = ST_RANGE;
      end else begin
        dec.op  = OP_REMOVE;
        dec.pos = pos;
      end
    end
  end

endmodule

// ===== rtl/ple_checker.sv =====
`include "positional_list_engine_core_macros.svh"

module ple_checker
  import ple_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     cmd_valid,
  input logic     cmd_stall,
  input ple_cmd_t cmd,
  input logic     res_valid,
  input logic     res_stall,
  input ple_res_t res
);

  // Hold a stalled result
  `PLE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result changed while stalled")

  // Block further requests right after one is taken
  `PLE_ASSERT_NEXT(a_busy_after_req, cmd_valid && !cmd_stall, cmd_stall, "request taken while still busy")

  // Rejections report a single bare status
  `PLE_ASSERT_IMPL(a_reject_clean, res_valid && res.status != ST_OK, res.last && res.item_value == '0 && res.item_index == '0, "rejected result carries data")

  // Only dump entries may be followed by more results
  `PLE_ASSERT_IMPL(a_notlast_ok, res_valid && !res.last, res.status == ST_OK && cmd_stall, "non-final result outside a dump")

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (.*);
